// File: sv/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg
// Shared types, sizes and command codes of the residue arithmetic unit.
// ----------------------------------------------------------------------------
package rra_pkg;

	localparam int CHANNELS  = 4;
	localparam int MOD_WIDTH = 16;
	localparam int VALUE_W   = 31;
	localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// dividend wide enough for a product of two residues or a binary value
	localparam int DIV_BITS  = (2 * MOD_WIDTH > VALUE_W) ? 2 * MOD_WIDTH : VALUE_W;

	// stage 0 captures the request, stage 1 forms the dividend,
	// then one quotient bit per stage
	localparam int NSTG      = 2 + DIV_BITS;

	// capped product of the moduli
	localparam int PROD_W    = VALUE_W + 1;
	localparam logic [PROD_W-1:0] PROD_CAP = {1'b1, {VALUE_W{1'b0}}};

	typedef logic [MOD_WIDTH-1:0] mod_t;
	typedef logic [VALUE_W-1:0]   val_t;
	typedef logic [DIV_BITS-1:0]  div_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [NSTG-1:0]      stg_en_t;

	typedef enum logic [1:0] {
		CMD_CONV = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_MUL  = 2'd2
	} cmd_t;

endpackage

// File: sv/rns_residue_alu_core.sv
// ----------------------------------------------------------------------------
// rns_residue_alu_core
// Four-channel residue arithmetic: convert, add and multiply per channel.
// ----------------------------------------------------------------------------
// One request per clock is taken while in_stall is low; each result passes
// through one capture stage, one operand stage, one restoring divider stage
// per dividend bit in every lane, then the output register. The depth is
// set by the bit-serial modulo pipeline. Empty stages close up
// while the output is stalled, so requests keep flowing until the pipeline
// is full. Moduli reset to 1 and may be written only while the unit is idle.
module rns_residue_alu_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rra_pkg::IDX_W-1:0] cfg_index,
	input  rra_pkg::mod_t             cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  rra_pkg::val_t             value,
	input  rra_pkg::mod_t             a_res_0,
	input  rra_pkg::mod_t             a_res_1,
	input  rra_pkg::mod_t             a_res_2,
	input  rra_pkg::mod_t             a_res_3,
	input  rra_pkg::mod_t             b_res_0,
	input  rra_pkg::mod_t             b_res_1,
	input  rra_pkg::mod_t             b_res_2,
	input  rra_pkg::mod_t             b_res_3,
	output logic                      out_valid,
	input  logic                      out_stall,
	output rra_pkg::mod_t             res_0,
	output rra_pkg::mod_t             res_1,
	output rra_pkg::mod_t             res_2,
	output rra_pkg::mod_t             res_3,
	output logic                      range_error
);
	import rra_pkg::*;

	mod_t    modulus_q [CHANNELS];
	mod_t    a_in [CHANNELS];
	mod_t    b_in [CHANNELS];
	mod_t    lane_res [CHANNELS];
	mod_t    res_q [CHANNELS];
	logic    err;
	logic    err_q;
	logic    out_valid_q;

	logic [NSTG-1:0] v_q;
	logic [NSTG:0]   ready;
	stg_en_t         en;

	assign a_in = '{a_res_0, a_res_1, a_res_2, a_res_3};
	assign b_in = '{b_res_0, b_res_1, b_res_2, b_res_3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++)
				modulus_q[i] <= MOD_WIDTH'(1);
		end else if (cfg_we && (32'(cfg_index) < CHANNELS)) begin
			modulus_q[cfg_index] <= cfg_data;
		end
	end

	// a stage advances when it is empty or the one after it advances
	always_comb begin
		ready[NSTG] = !out_valid_q || !out_stall;
		for (int k = NSTG - 1; k >= 0; k--)
			ready[k] = !v_q[k] || ready[k+1];
		en = ready[NSTG-1:0];
	end

	assign in_stall = !ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready[0])
				v_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++)
				if (ready[k])
					v_q[k] <= v_q[k-1];
			if (ready[NSTG])
				out_valid_q <= v_q[NSTG-1];
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		rra_lane u_lane (
			.clk    (clk),
			.en     (en),
			.cmd    (command),
			.val    (value),
			.a      (a_in[i]),
			.b      (b_in[i]),
			.m      (modulus_q[i]),
			.res    (lane_res[i])
		);
	end

	rra_range u_range (
		.clk (clk),
		.en  (en),
		.cmd (command),
		.val (value),
		.m   (modulus_q),
		.err (err)
	);

	// merge lanes and range flag into the output register
	always_ff @(posedge clk) begin
		if (ready[NSTG]) begin
			res_q <= lane_res;
			err_q <= err;
		end
	end

	assign out_valid   = out_valid_q;
	assign res_0       = res_q[0];
	assign res_1       = res_q[1];
	assign res_2       = res_q[2];
	assign res_3       = res_q[3];
	assign range_error = err_q;

	a_accept_fills : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[0])
		else $error("accepted request not captured");

	a_empty_ready : assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[0] |-> !in_stall)
		else $error("stall with empty capture stage");

	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_0) && $stable(range_error))
		else $error("stalled result changed");

	a_last_drain : assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NSTG-1] && !out_valid |=> out_valid)
		else $error("finished request not moved to output");

endmodule

// File: sv/rra_lane.sv
// ----------------------------------------------------------------------------
// rra_lane
// One residue channel: forms the dividend for the command and reduces it
// modulo the channel modulus with a restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module rra_lane (
	input  logic             clk,
	input  rra_pkg::stg_en_t en,
	input  logic [1:0]       cmd,
	input  rra_pkg::val_t    val,
	input  rra_pkg::mod_t    a,
	input  rra_pkg::mod_t    b,
	input  rra_pkg::mod_t    m,
	output rra_pkg::mod_t    res
);
	import rra_pkg::*;

	logic [1:0] cmd_s0;
	val_t       val_s0;
	mod_t       a_s0;
	mod_t       b_s0;

	div_t d_q [NSTG];
	mod_t r_q [NSTG];
	logic z_q [NSTG];

	div_t dividend;
	logic zero_res;

	always_comb begin
		dividend = '0;
		zero_res = (m == '0);
		case (cmd_s0)
			CMD_CONV: dividend = DIV_BITS'(val_s0);
			CMD_ADD:  dividend = DIV_BITS'({1'b0, a_s0} + {1'b0, b_s0});
			CMD_MUL:  dividend = DIV_BITS'(a_s0) * DIV_BITS'(b_s0);
			default:  zero_res = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s0 <= cmd;
			val_s0 <= val;
			a_s0   <= a;
			b_s0   <= b;
		end
		if (en[1]) begin
			d_q[1] <= dividend;
			r_q[1] <= '0;
			z_q[1] <= zero_res;
		end
		for (int k = 2; k < NSTG; k++) begin
			if (en[k]) begin
				logic [MOD_WIDTH:0] t;
				t = {r_q[k-1], d_q[k-1][DIV_BITS-1]};
				if (t >= {1'b0, m})
					r_q[k] <= MOD_WIDTH'(t - {1'b0, m});
				else
					r_q[k] <= t[MOD_WIDTH-1:0];
				d_q[k] <= {d_q[k-1][DIV_BITS-2:0], 1'b0};
				z_q[k] <= z_q[k-1];
			end
		end
	end

	// a zero modulus or an undefined command gives zero
	assign res = z_q[NSTG-1] ? '0 : r_q[NSTG-1];

endmodule

// File: sv/rra_range.sv
// ----------------------------------------------------------------------------
// rra_range
// Range check of convert: multiplies the moduli one per stage with
// saturation and compares the value against the product.
// ----------------------------------------------------------------------------
module rra_range (
	input  logic             clk,
	input  rra_pkg::stg_en_t en,
	input  logic [1:0]       cmd,
	input  rra_pkg::val_t    val,
	input  rra_pkg::mod_t    m [rra_pkg::CHANNELS],
	output logic             err
);
	import rra_pkg::*;

	localparam int ERR_STG = CHANNELS + 1;

	logic  conv_q [NSTG];
	val_t  val_q  [NSTG];
	prod_t p_q    [NSTG];
	logic  err_q  [NSTG];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			conv_q[0] <= (cmd == CMD_CONV);
			val_q[0]  <= val;
		end
		if (en[1]) begin
			conv_q[1] <= conv_q[0];
			val_q[1]  <= val_q[0];
			p_q[1]    <= PROD_W'(m[0]);
		end
		for (int k = 2; k <= CHANNELS; k++) begin
			if (en[k]) begin
				logic [PROD_W+MOD_WIDTH-1:0] pr;
				pr = p_q[k-1] * m[k-1];
				conv_q[k] <= conv_q[k-1];
				val_q[k]  <= val_q[k-1];
				p_q[k]    <= (pr > (PROD_W+MOD_WIDTH)'(PROD_CAP)) ? PROD_CAP : PROD_W'(pr);
			end
		end
		if (en[ERR_STG])
			err_q[ERR_STG] <= conv_q[ERR_STG-1] && ({1'b0, val_q[ERR_STG-1]} >= p_q[ERR_STG-1]);
		for (int k = ERR_STG + 1; k < NSTG; k++) begin
			if (en[k])
				err_q[k] <= err_q[k-1];
		end
	end

	assign err = err_q[NSTG-1];

endmodule
